/* rtl/hpc_pkg.sv */
// shared constants, types and command codes of the prototype classifier
`default_nettype none
package hpc_pkg;
  localparam int MaxProto = 64;
  localparam int VecDims = 16;
  localparam int IdxW = $clog2(MaxProto);
  localparam int CntW = $clog2(MaxProto + 1);
  localparam int PosW = $clog2(VecDims);
  localparam int AddrW = IdxW + PosW;
  localparam int ElemW = 16;
  localparam int DiffW = ElemW + 1;
  localparam int SqW = 2 * DiffW;
  localparam int SumW = SqW + PosW;
  localparam int RadW = 39;
  localparam int ScoreW = 40;
  localparam int ClsW = 5;
  localparam int RootW = (SumW + 1) / 2;

  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_FIRST = 2'd1;
  localparam logic [1:0] CFG_SPAN = 2'd2;
  localparam logic [1:0] CFG_FLOOR = 2'd3;

  localparam logic signed [ScoreW-1:0] FLOOR_RESET = -40'sd255744;
  localparam logic signed [ClsW-1:0] NO_CLASS = -5'sd1;

  // controller to datapath
  typedef struct packed {
    logic take_in;      // accept element word
    logic sum_clear;    // start a new prototype
    logic acc_en;       // accumulate one product
    logic sqrt_start;
    logic score_en;     // compare a finished distance
    logic best_init;
  } hpc_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } hpc_stat_t;
endpackage
`default_nettype wire

/* rtl/hpc_isqrt.sv */
// iterative floor square root, two radicand bits in and one root bit out per cycle
`default_nettype none
module hpc_isqrt (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [hpc_pkg::SumW-1:0] radicand,
  output logic done,
  output logic [hpc_pkg::RootW-1:0] root
);
  localparam int StepW = $clog2(hpc_pkg::RootW + 1);
  localparam int RemW = hpc_pkg::RootW + 2;
  localparam int OpW = 2 * hpc_pkg::RootW;

  logic [OpW-1:0] op_r, op_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic [hpc_pkg::RootW-1:0] root_r, root_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [RemW-1:0] trial, shifted;

  always_comb begin
    op_nxt = op_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[RemW-3:0], op_r[OpW-1 -: 2]};
    trial = {root_r, 2'b01};
    if (start) begin
      op_nxt = OpW'(radicand);
      rem_nxt = '0;
      root_nxt = '0;
      cnt_nxt = StepW'(hpc_pkg::RootW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      op_nxt = {op_r[OpW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        root_nxt = {root_r[hpc_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        root_nxt = {root_r[hpc_pkg::RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    op_r <= op_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

/* rtl/hpc_datapath.sv */
// stores, sample buffer, distance accumulator and best-score tracking
`default_nettype none
module hpc_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire hpc_pkg::hpc_cmd_t cmd,
  output hpc_pkg::hpc_stat_t stat,
  // element word
  input  wire logic [hpc_pkg::RadW-1:0] in_radius_value,
  input  wire logic signed [hpc_pkg::ClsW-1:0] in_class_label,
  // store/fill port from controller
  input  wire logic fill_we,
  input  wire logic fill_sample,
  input  wire logic [hpc_pkg::PosW-1:0] fill_pos,
  input  wire logic signed [hpc_pkg::ElemW-1:0] fill_val,
  input  wire logic [hpc_pkg::IdxW-1:0] row_idx,
  input  wire logic meta_we,
  // scoring walk
  input  wire logic [hpc_pkg::IdxW-1:0] scan_idx,
  input  wire logic [hpc_pkg::PosW-1:0] scan_pos,
  input  wire logic mode,
  input  wire logic signed [hpc_pkg::ScoreW-1:0] floor_val,
  output logic signed [hpc_pkg::ScoreW-1:0] best_score,
  output logic [hpc_pkg::IdxW-1:0] best_idx,
  output logic best_found,
  output logic signed [hpc_pkg::ClsW-1:0] best_class
);
  logic signed [hpc_pkg::ElemW-1:0] proto_mem [hpc_pkg::MaxProto*hpc_pkg::VecDims];
  logic [hpc_pkg::RadW-1:0] rad_mem [hpc_pkg::MaxProto];
  logic signed [hpc_pkg::ClsW-1:0] cls_mem [hpc_pkg::MaxProto];
  logic signed [hpc_pkg::ElemW-1:0] samp_r [hpc_pkg::VecDims];

  logic signed [hpc_pkg::ElemW-1:0] prd_r, smp_r;
  logic [hpc_pkg::RadW-1:0] rad_rd_r;
  logic signed [hpc_pkg::ClsW-1:0] cls_rd_r;
  logic [hpc_pkg::SumW-1:0] sum_r;
  logic [hpc_pkg::SqW-1:0] sq_r;
  logic signed [hpc_pkg::DiffW-1:0] diff;
  logic [hpc_pkg::RootW-1:0] root;
  logic [hpc_pkg::IdxW-1:0] cur_idx_r;
  logic signed [hpc_pkg::ScoreW-1:0] sc;
  logic [hpc_pkg::SumW-1:0] dist_v;

  always_ff @(posedge clk) begin
    if (fill_we && !fill_sample)
      proto_mem[{row_idx, fill_pos}] <= fill_val;
    if (fill_we && fill_sample)
      samp_r[fill_pos] <= fill_val;
    if (meta_we) begin
      rad_mem[row_idx] <= in_radius_value;
      cls_mem[row_idx] <= in_class_label;
    end
    prd_r <= proto_mem[{scan_idx, scan_pos}];
    smp_r <= samp_r[scan_pos];
    rad_rd_r <= rad_mem[cur_idx_r];
    cls_rd_r <= cls_mem[best_idx];
  end

  assign diff = hpc_pkg::DiffW'(prd_r) - hpc_pkg::DiffW'(smp_r);

  hpc_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start), .radicand(sum_r),
    .done(stat.sqrt_done), .root(root)
  );

  assign dist_v = mode ? (sum_r >> 8) : hpc_pkg::SumW'(root);
  assign sc = $signed({1'b0, rad_rd_r}) - $signed({1'b0, hpc_pkg::RadW'(dist_v)});

  always_ff @(posedge clk) begin
    sq_r <= hpc_pkg::SqW'(diff * diff);
    if (cmd.sum_clear) begin
      sum_r <= '0;
      cur_idx_r <= scan_idx;
    end else if (cmd.acc_en)
      sum_r <= sum_r + hpc_pkg::SumW'(sq_r);
    if (!rst_n) begin
      best_found <= 1'b0;
    end else if (cmd.best_init) begin
      best_found <= 1'b0;
    end else if (cmd.score_en && (sc > best_score)) begin
      best_found <= 1'b1;
    end
    if (cmd.best_init) begin
      best_score <= floor_val;
      best_idx <= '0;
    end else if (cmd.score_en && (sc > best_score)) begin
      best_score <= sc;
      best_idx <= cur_idx_r;
    end
  end
  assign best_class = cls_rd_r;
endmodule
`default_nettype wire

/* rtl/hpc_ctrl.sv */
// sequencer: element intake, table count and window walk
`default_nettype none
module hpc_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_command,
  input  wire logic signed [hpc_pkg::ElemW-1:0] in_element_value,
  input  wire logic in_last_element,
  input  wire logic [hpc_pkg::IdxW-1:0] first_neuron,
  input  wire logic [hpc_pkg::CntW-1:0] neuron_span,
  input  wire logic mode,
  output hpc_pkg::hpc_cmd_t cmd,
  input  wire hpc_pkg::hpc_stat_t stat,
  output logic fill_we,
  output logic fill_sample,
  output logic [hpc_pkg::PosW-1:0] fill_pos,
  output logic signed [hpc_pkg::ElemW-1:0] fill_val,
  output logic [hpc_pkg::IdxW-1:0] row_idx,
  output logic meta_we,
  output logic [hpc_pkg::IdxW-1:0] scan_idx,
  output logic [hpc_pkg::PosW-1:0] scan_pos,
  output logic res_valid,
  output logic res_classify,
  output logic res_full,
  output logic [hpc_pkg::CntW-1:0] count
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD = 3'd1;
  localparam logic [2:0] S_ACC = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_SCORE = 3'd4;
  localparam logic [2:0] S_CLS = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam int AccLen = hpc_pkg::VecDims + 3;
  localparam int AccW = $clog2(AccLen + 1);

  logic [2:0] st_r, st_nxt;
  logic [hpc_pkg::PosW-1:0] pos_r, pos_nxt, pad_r, pad_nxt;
  logic [hpc_pkg::CntW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, end_r, end_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic pad_smp_r, pad_smp_nxt, full_r, full_nxt;
  logic rv_r, rv_nxt, rc_r, rc_nxt;
  logic full;
  logic [hpc_pkg::CntW:0] wend, span;

  assign full = cnt_r >= hpc_pkg::CntW'(hpc_pkg::MaxProto);

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; pad_nxt = pad_r; cnt_nxt = cnt_r;
    idx_nxt = idx_r; end_nxt = end_r; acc_nxt = acc_r;
    pad_smp_nxt = pad_smp_r; full_nxt = full_r;
    rv_nxt = 1'b0; rc_nxt = 1'b0;
    cmd = '0;
    fill_we = 1'b0; fill_sample = 1'b0; fill_pos = pos_r; fill_val = in_element_value;
    meta_we = 1'b0;
    row_idx = hpc_pkg::IdxW'(cnt_r);
    scan_idx = hpc_pkg::IdxW'(idx_r);
    scan_pos = hpc_pkg::PosW'(acc_r);
    span = {1'b0, neuron_span};
    if (neuron_span == '0 ||
        ({1'b0, hpc_pkg::CntW'(first_neuron)} + {1'b0, neuron_span}) >
          (hpc_pkg::CntW+1)'(hpc_pkg::MaxProto))
      span = {1'b0, cnt_r};
    wend = {1'b0, hpc_pkg::CntW'(first_neuron)} + span;
    if (wend > {1'b0, cnt_r}) wend = {1'b0, cnt_r};
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_command)
            hpc_pkg::CMD_CLEAR: begin
              cnt_nxt = '0; pos_nxt = '0; rv_nxt = 1'b1; full_nxt = 1'b0;
            end
            hpc_pkg::CMD_STORE, hpc_pkg::CMD_CLASSIFY: begin
              fill_sample = (in_command == hpc_pkg::CMD_CLASSIFY);
              fill_we = fill_sample || !full;
              if (!in_last_element) begin
                if (pos_r != hpc_pkg::PosW'(hpc_pkg::VecDims - 1))
                  pos_nxt = pos_r + 1'b1;
              end else begin
                pos_nxt = '0;
                pad_nxt = pos_r;
                pad_smp_nxt = fill_sample;
                full_nxt = full && !fill_sample;
                if (!fill_sample && !full) meta_we = 1'b1;
                st_nxt = S_PAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        // zero the tail of a short vector
        if (pad_r != hpc_pkg::PosW'(hpc_pkg::VecDims - 1)) begin
          fill_pos = pad_r + 1'b1;
          fill_val = '0;
          fill_sample = pad_smp_r;
          fill_we = pad_smp_r || !full_r;
          pad_nxt = pad_r + 1'b1;
        end else if (!pad_smp_r) begin
          if (!full_r) cnt_nxt = cnt_r + 1'b1;
          rv_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          cmd.best_init = 1'b1;
          idx_nxt = hpc_pkg::CntW'(first_neuron);
          end_nxt = hpc_pkg::CntW'(wend);
          st_nxt = S_CLS;
        end
      end
      S_CLS: begin
        if (idx_r >= end_r) st_nxt = S_DONE;
        else begin
          cmd.sum_clear = 1'b1;
          acc_nxt = '0;
          st_nxt = S_ACC;
        end
      end
      S_ACC: begin
        // the read (prd_r, smp_r) and the square (sq_r) are registered, so the add trails the address
        acc_nxt = acc_r + 1'b1;
        if (acc_r >= AccW'(2) && acc_r < AccW'(AccLen - 1)) cmd.acc_en = 1'b1;
        if (acc_r == AccW'(AccLen - 1)) begin
          if (mode) st_nxt = S_SCORE;
          else begin
            cmd.sqrt_start = 1'b1;
            st_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: if (stat.sqrt_done) st_nxt = S_SCORE;
      S_SCORE: begin
        cmd.score_en = 1'b1;
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_CLS;
      end
      S_DONE: begin
        // class read is registered on the winner index
        rv_nxt = 1'b1; rc_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pos_r <= '0; cnt_r <= '0; rv_r <= 1'b0; rc_r <= 1'b0;
      full_r <= 1'b0; pad_r <= '0; pad_smp_r <= 1'b0; idx_r <= '0; end_r <= '0; acc_r <= '0;
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; cnt_r <= cnt_nxt; rv_r <= rv_nxt; rc_r <= rc_nxt;
      full_r <= full_nxt; pad_r <= pad_nxt; pad_smp_r <= pad_smp_nxt;
      idx_r <= idx_nxt; end_r <= end_nxt; acc_r <= acc_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign res_valid = rv_r;
  assign res_classify = rc_r;
  assign res_full = full_r;
  assign count = cnt_r;
endmodule
`default_nettype wire

/* rtl/hypersphere_prototype_classifier_unit.sv */
// top level: configuration registers, sequencer and datapath
// element words are taken while idle; a last word zeroes the tail of a short vector
// classify: per window prototype, accumulate the squared distance, take its root (root mode), score
// root mode waits on the one-bit-per-cycle square root unit
// synchronous active-low reset clears count, position and registers
// results are a one-cycle strobe; the receiver cannot stall
`default_nettype none
module hypersphere_prototype_classifier_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_command,
  input  wire logic signed [15:0] in_element_value,
  input  wire logic in_last_element,
  input  wire logic [38:0] in_radius_value,
  input  wire logic signed [4:0] in_class_label,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [39:0] cfg_data,
  output logic out_valid,
  output logic signed [39:0] out_score,
  output logic [5:0] out_winner_index,
  output logic out_winner_found,
  output logic signed [4:0] out_predicted_class,
  output logic out_table_full,
  output logic [6:0] out_stored_total
);
  logic mode_r;
  logic [hpc_pkg::IdxW-1:0] first_r;
  logic [hpc_pkg::CntW-1:0] span_r;
  logic signed [hpc_pkg::ScoreW-1:0] floor_r;
  hpc_pkg::hpc_cmd_t cmd;
  hpc_pkg::hpc_stat_t stat;
  logic fill_we, fill_sample, meta_we, rv, rc, rfull;
  logic [hpc_pkg::PosW-1:0] fill_pos, scan_pos;
  logic signed [hpc_pkg::ElemW-1:0] fill_val;
  logic [hpc_pkg::IdxW-1:0] row_idx, scan_idx, bidx;
  logic [hpc_pkg::CntW-1:0] cnt;
  logic signed [hpc_pkg::ScoreW-1:0] bscore;
  logic bfound;
  logic signed [hpc_pkg::ClsW-1:0] bcls;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; first_r <= '0; span_r <= '0; floor_r <= hpc_pkg::FLOOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hpc_pkg::CFG_MODE: mode_r <= cfg_data[0];
        hpc_pkg::CFG_FIRST: first_r <= cfg_data[hpc_pkg::IdxW-1:0];
        hpc_pkg::CFG_SPAN: span_r <= cfg_data[hpc_pkg::CntW-1:0];
        hpc_pkg::CFG_FLOOR: floor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_element_value(in_element_value),
    .in_last_element(in_last_element), .first_neuron(first_r), .neuron_span(span_r),
    .mode(mode_r), .cmd(cmd), .stat(stat), .fill_we(fill_we), .fill_sample(fill_sample),
    .fill_pos(fill_pos), .fill_val(fill_val), .row_idx(row_idx), .meta_we(meta_we),
    .scan_idx(scan_idx), .scan_pos(scan_pos), .res_valid(rv), .res_classify(rc),
    .res_full(rfull), .count(cnt)
  );

  hpc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_radius_value(in_radius_value),
    .in_class_label(in_class_label), .fill_we(fill_we), .fill_sample(fill_sample),
    .fill_pos(fill_pos), .fill_val(fill_val), .row_idx(row_idx), .meta_we(meta_we),
    .scan_idx(scan_idx), .scan_pos(scan_pos), .mode(mode_r), .floor_val(floor_r),
    .best_score(bscore), .best_idx(bidx), .best_found(bfound), .best_class(bcls)
  );

  assign out_valid = rv;
  assign out_score = rc ? bscore : '0;
  assign out_winner_index = (rc && bfound) ? bidx : '0;
  assign out_winner_found = rc && bfound;
  assign out_predicted_class = (rc && bfound && !bscore[hpc_pkg::ScoreW-1]) ?
                               bcls : hpc_pkg::NO_CLASS;
  assign out_table_full = !rc && rfull;
  assign out_stored_total = cnt;
endmodule
`default_nettype wire

/* bench/hypersphere_prototype_classifier_unit_tb.sv */
// testbench of the hypersphere prototype classifier: directed table, random phases, predictor
`default_nettype none
module hypersphere_prototype_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int ItemTarget = 1900;
  localparam int QuietTail = 1700;
  localparam int StallLimit = 20000;
  localparam logic signed [39:0] FLOOR_MIN = -40'sh8000000000;
  localparam logic [38:0] RAD_MAX = 39'h4000000000;

  typedef struct packed {
    logic signed [39:0] score;
    logic [5:0] idx;
    logic found;
    logic signed [4:0] pred;
    logic full;
    logic [6:0] total;
  } verdict_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [15:0] val;
    logic last;
    logic [38:0] rad;
    logic signed [4:0] cls;
    logic [7:0] rpt;
    logic typed;
    verdict_t res;
  } row_t;

  localparam verdict_t QUIET0 = '{40'sd0, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd0};

  localparam int PlanLen = 17;
  localparam row_t PLAN [PlanLen] = '{
    '{hpc_pkg::CMD_CLASSIFY, 16'sd0, 1'b1, 39'd0, 5'sd0, 8'd1, 1'b1,
      '{hpc_pkg::FLOOR_RESET, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd0}},
    '{hpc_pkg::CMD_STORE, 16'sh7fff, 1'b0, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0},
    '{hpc_pkg::CMD_STORE, -16'sh8000, 1'b1, RAD_MAX, 5'sd15, 8'd1, 1'b1,
      '{40'sd0, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd1}},
    '{hpc_pkg::CMD_STORE, 16'sd0, 1'b1, 39'd0, -5'sd1, 8'd1, 1'b1,
      '{40'sd0, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd2}},
    '{hpc_pkg::CMD_CLASSIFY, 16'sh7fff, 1'b0, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0},
    '{hpc_pkg::CMD_CLASSIFY, -16'sh8000, 1'b1, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0},
    '{CMD_NONE, 16'sd77, 1'b1, 39'd5, 5'sd2, 8'd1, 1'b0, QUIET0},
    '{hpc_pkg::CMD_STORE, 16'sd256, 1'b0, 39'd0, 5'sd0, 8'd17, 1'b0, QUIET0},
    '{hpc_pkg::CMD_STORE, 16'sd100, 1'b1, 39'd1000, 5'sd3, 8'd1, 1'b1,
      '{40'sd0, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd3}},
    '{hpc_pkg::CMD_CLASSIFY, 16'sd256, 1'b0, 39'd0, 5'sd0, 8'd15, 1'b0, QUIET0},
    '{hpc_pkg::CMD_CLASSIFY, 16'sd100, 1'b1, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0},
    '{hpc_pkg::CMD_STORE, 16'sd5, 1'b0, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0},
    '{hpc_pkg::CMD_CLASSIFY, -16'sd5, 1'b1, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0},
    '{hpc_pkg::CMD_CLEAR, 16'sd0, 1'b0, 39'd0, 5'sd0, 8'd1, 1'b1, QUIET0},
    '{hpc_pkg::CMD_CLASSIFY, 16'sd1, 1'b1, 39'd0, 5'sd0, 8'd1, 1'b1,
      '{hpc_pkg::FLOOR_RESET, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd0}},
    '{hpc_pkg::CMD_STORE, -16'sd1, 1'b1, 39'd12345, 5'sd7, 8'd1, 1'b1,
      '{40'sd0, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd1}},
    '{hpc_pkg::CMD_CLASSIFY, -16'sd1, 1'b1, 39'd0, 5'sd0, 8'd1, 1'b0, QUIET0}
  };

  logic clk, rst_n, start, busy;
  logic [1:0] in_command;
  logic signed [15:0] in_element_value;
  logic in_last_element;
  logic [38:0] in_radius_value;
  logic signed [4:0] in_class_label;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [39:0] cfg_data;
  logic out_valid;
  logic signed [39:0] out_score;
  logic [5:0] out_winner_index;
  logic out_winner_found;
  logic signed [4:0] out_predicted_class;
  logic out_table_full;
  logic [6:0] out_stored_total;

  hypersphere_prototype_classifier_unit u_dut (.*);

  // predictor copy of the block state and registers
  logic signed [15:0] proto_mem [hpc_pkg::MaxProto][hpc_pkg::VecDims];
  logic [38:0] radius_mem [hpc_pkg::MaxProto];
  logic signed [4:0] label_mem [hpc_pkg::MaxProto];
  logic signed [15:0] sample_mem [hpc_pkg::VecDims];
  int held;
  int slot;
  bit sq_mode;
  int win_first, win_span;
  logic signed [39:0] floor_reg;

  verdict_t pending [$];
  int errors;
  int words_sent;
  bit idle_on;
  int stall_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // best hypersphere over the search window for the buffered sample
  function automatic verdict_t best_sphere();
    verdict_t v;
    int lo, span, hi;
    longint best, sc, d;
    longint unsigned sum, dist_v;
    v = '0;
    lo = win_first;
    span = win_span;
    if (span == 0 || lo + span > hpc_pkg::MaxProto) span = held;
    hi = lo + span;
    if (hi > held) hi = held;
    best = longint'(floor_reg);
    for (int i = lo; i < hi; i++) begin
      sum = 0;
      for (int k = 0; k < hpc_pkg::VecDims; k++) begin
        d = longint'(proto_mem[i][k]) - longint'(sample_mem[k]);
        sum += longint'(d * d);
      end
      dist_v = sq_mode ? (sum >> 8) : root_floor(sum);
      sc = longint'({25'd0, radius_mem[i]}) - longint'(dist_v);
      if (best < sc) begin
        best = sc;
        v.idx = i[5:0];
        v.found = 1'b1;
      end
    end
    v.score = best[39:0];
    v.pred = (v.found && best >= 0) ? label_mem[v.idx] : hpc_pkg::NO_CLASS;
    v.total = held[6:0];
    return v;
  endfunction

  // advances the predictor by one accepted word; returns 1 when a result follows
  function automatic bit take_word(input logic [1:0] cmd, input logic signed [15:0] val,
                                   input logic last, input logic [38:0] rad,
                                   input logic signed [4:0] cls, output verdict_t v);
    bit full;
    v = '{40'sd0, 6'd0, 1'b0, hpc_pkg::NO_CLASS, 1'b0, 7'd0};
    case (cmd)
      hpc_pkg::CMD_CLEAR: begin
        held = 0;
        slot = 0;
        return 1'b1;
      end
      hpc_pkg::CMD_STORE: begin
        full = held >= hpc_pkg::MaxProto;
        if (!full) proto_mem[held][slot] = val;
        if (!last) begin
          if (slot < hpc_pkg::VecDims - 1) slot++;
          return 1'b0;
        end
        if (!full) begin
          for (int k = slot + 1; k < hpc_pkg::VecDims; k++) proto_mem[held][k] = '0;
          radius_mem[held] = rad;
          label_mem[held] = cls;
          held++;
        end
        slot = 0;
        v.full = full;
        v.total = held[6:0];
        return 1'b1;
      end
      hpc_pkg::CMD_CLASSIFY: begin
        sample_mem[slot] = val;
        if (!last) begin
          if (slot < hpc_pkg::VecDims - 1) slot++;
          return 1'b0;
        end
        for (int k = slot + 1; k < hpc_pkg::VecDims; k++) sample_mem[k] = '0;
        slot = 0;
        v = best_sphere();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic signed [15:0] val,
                           input logic last, input logic [38:0] rad,
                           input logic signed [4:0] cls, input bit use_typed,
                           input verdict_t typed_res);
    verdict_t v;
    if (idle_on && words_sent < QuietTail && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_element_value <= val;
    in_last_element <= last;
    in_radius_value <= rad;
    in_class_label <= cls;
    do @(posedge clk); while (busy);
    if (cmd != CMD_NONE) words_sent++;
    if (take_word(cmd, val, last, rad, cls, v)) pending.push_back(use_typed ? typed_res : v);
  endtask

  // lets the block drain, including tail work of words with no result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [39:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hpc_pkg::CFG_MODE: sq_mode = data[0];
      hpc_pkg::CFG_FIRST: win_first = int'(data[5:0]);
      hpc_pkg::CFG_SPAN: win_span = int'(data[6:0]);
      default: floor_reg = data;
    endcase
  endtask

  function automatic logic signed [15:0] pick_elem(input bit near);
    case ($urandom_range(0, 15))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'sd0;
      default: return near ? 16'(int'($urandom_range(0, 1023)) - 512) : 16'($urandom);
    endcase
  endfunction

  function automatic logic [38:0] pick_radius(input bit near);
    case ($urandom_range(0, 11))
      0: return RAD_MAX;
      1: return 39'd0;
      2: return 39'({$urandom, $urandom}) & 39'h3fffffffff;
      default: return near ? 39'($urandom_range(0, 16000)) : 39'($urandom_range(0, 2000000));
    endcase
  endfunction

  task automatic send_vector(input logic [1:0] cmd, input int len, input bit near);
    logic [38:0] rad;
    logic signed [4:0] cls;
    rad = pick_radius(near);
    cls = 5'(int'($urandom_range(0, 16)) - 1);
    for (int k = 0; k < len; k++)
      send_word(cmd, pick_elem(near), k == len - 1, rad, cls, 1'b0, '0);
  endtask

  task automatic run_phase();
    bit near;
    int n;
    near = $urandom_range(0, 3) != 0;
    idle_on = $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 4) == 0) begin
      // fill the table past capacity with short vectors
      while (held < hpc_pkg::MaxProto)
        send_vector(hpc_pkg::CMD_STORE, $urandom_range(1, 3), near);
      repeat (3) send_vector(hpc_pkg::CMD_STORE, $urandom_range(1, 4), near);
      repeat (3) send_vector(hpc_pkg::CMD_CLASSIFY, $urandom_range(1, 16), near);
    end else begin
      n = $urandom_range(6, 14);
      repeat (n) begin
        case ($urandom_range(0, 29))
          0: send_word(hpc_pkg::CMD_CLEAR, pick_elem(near), 1'($urandom_range(0, 1)),
                       '0, '0, 1'b0, '0);
          1: send_word(CMD_NONE, pick_elem(near), 1'($urandom_range(0, 1)),
                       pick_radius(near), 5'($urandom), 1'b0, '0);
          2: begin
            // store words cut off by a classify that finishes the vector
            repeat ($urandom_range(1, 6)) send_word(hpc_pkg::CMD_STORE, pick_elem(near),
                                                    1'b0, '0, '0, 1'b0, '0);
            send_vector(hpc_pkg::CMD_CLASSIFY, $urandom_range(1, 8), near);
          end
          3, 4: send_vector($urandom_range(0, 1) ? hpc_pkg::CMD_STORE : hpc_pkg::CMD_CLASSIFY,
                            $urandom_range(17, 22), near);
          default: begin
            if (held > 40 && $urandom_range(0, 3) != 0)
              send_vector(hpc_pkg::CMD_CLASSIFY, $urandom_range(1, 16), near);
            else
              send_vector($urandom_range(0, 2) == 0 ? hpc_pkg::CMD_CLASSIFY :
                          hpc_pkg::CMD_STORE, $urandom_range(1, 16), near);
          end
        endcase
      end
    end
  endtask

  task automatic new_settings();
    logic [39:0] fl;
    int pick;
    write_reg(hpc_pkg::CFG_MODE, {39'd0, 1'($urandom)});
    pick = $urandom_range(0, 5);
    write_reg(hpc_pkg::CFG_FIRST,
              pick == 0 ? 40'd63 : pick == 1 ? 40'd0 : 40'($urandom_range(0, 20)));
    pick = $urandom_range(0, 7);
    write_reg(hpc_pkg::CFG_SPAN, pick == 0 ? 40'd64 : pick == 1 ? 40'd127 :
                                 pick < 4 ? 40'd0 : 40'($urandom_range(1, 64)));
    case ($urandom_range(0, 4))
      0: fl = FLOOR_MIN;
      1: fl = '0;
      2: fl = hpc_pkg::FLOOR_RESET;
      default: fl = -40'($urandom_range(1, 1000000));
    endcase
    write_reg(hpc_pkg::CFG_FLOOR, fl);
  endtask

  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        w = pending.pop_front();
        if (out_score !== w.score) report("score", out_score, w.score);
        if (out_winner_index !== w.idx) report("winner_index", out_winner_index, w.idx);
        if (out_winner_found !== w.found) report("winner_found", out_winner_found, w.found);
        if (out_predicted_class !== w.pred)
          report("predicted_class", out_predicted_class, w.pred);
        if (out_table_full !== w.full) report("table_full", out_table_full, w.full);
        if (out_stored_total !== w.total) report("stored_total", out_stored_total, w.total);
      end
    end
  end

  // cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = hpc_pkg::CMD_STORE;
    in_element_value = '0;
    in_last_element = 1'b0;
    in_radius_value = '0;
    in_class_label = '0;
    cfg_valid = 1'b0;
    cfg_index = hpc_pkg::CFG_MODE;
    cfg_data = '0;
    errors = 0;
    words_sent = 0;
    stall_cnt = 0;
    held = 0;
    slot = 0;
    sq_mode = 1'b0;
    win_first = 0;
    win_span = 0;
    floor_reg = hpc_pkg::FLOOR_RESET;
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < PlanLen; r++)
      repeat (PLAN[r].rpt)
        send_word(PLAN[r].cmd, PLAN[r].val, PLAN[r].last, PLAN[r].rad, PLAN[r].cls,
                  PLAN[r].typed, PLAN[r].res);
    while (words_sent < ItemTarget) begin
      settle();
      new_settings();
      run_phase();
    end
    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
rtl/hpc_pkg.sv
rtl/hpc_isqrt.sv
rtl/hpc_datapath.sv
rtl/hpc_ctrl.sv
rtl/hypersphere_prototype_classifier_unit.sv
bench/hypersphere_prototype_classifier_unit_tb.sv
